@@ rtl/core/bsde_pkg.sv @@
package bsde_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int MAX_DEGREE_DEF = 3;

    // Fixed field widths
    localparam int QW  = 32;   // Q16.16 coordinate
    localparam int CW  = 6;    // cv_count
    localparam int PIW = 5;    // point_index
    localparam int CIW = 3;    // config register index
    localparam int IXW = 8;    // knot index arithmetic
    localparam int AFW = 18;   // signed multiplier B operand
    localparam int MW  = 51;   // product / accumulator
    localparam int DNW = 50;   // divider dividend magnitude
    localparam int DDW = 34;   // divider divisor

    localparam logic [16:0] ONE_Q = 17'd65536;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CIW-1:0] CFG_CV_COUNT  = 3'd0;
    localparam logic [CIW-1:0] CFG_DEGREE    = 3'd1;
    localparam logic [CIW-1:0] CFG_REMAP     = 3'd2;
    localparam logic [CIW-1:0] CFG_RANGE_MIN = 3'd3;
    localparam logic [CIW-1:0] CFG_RANGE_MAX = 3'd4;

    localparam logic [1:0] ST_EVAL   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_SINGLE = 2'd2;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } point_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SINGLE,
        S_SRCH,
        S_SRCH_CHK,
        S_KNOT,
        S_KNOT_MUL,
        S_KNOT_FIN,
        S_DIV,
        S_LOAD,
        S_LOAD_WR,
        S_STEP,
        S_STEP_LO,
        S_STEP_HI,
        S_ALPHA_FIN,
        S_RDP,
        S_RDQ,
        S_BL_M1,
        S_BL_M2,
        S_BL_ACC,
        S_FINISH
    } state_t;

endpackage

@@ rtl/core/bsde_ram.sv @@
module bsde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/bspline_de_boor_evaluator.sv @@
// Channel   | Signals                                         | Handshake
// ----------+-------------------------------------------------+---------------------------
// command   | cmd point_index write_x/y/z param_t             | start & !busy
// config    | cfg_index cfg_data                              | cfg_valid & cfg_ready
// result    | out_x out_y out_z curve_status                  | done, one cycle, no stall
//
// A point write is taken in the accept cycle and keeps busy low; it gives no result.
// A sample with no points answers in the next cycle, with one point via S_SINGLE.
// Otherwise: span search (remapped knots also divide), load of deg+1 points (S_LOAD,
// S_LOAD_WR each), then deg*(deg+1)/2 steps, each two knot lookups, an alpha
// division in the shared restoring divider unless the knot gap or x minus the left
// knot is <= 0, and reads and blends on the shared multiplier; the divider dominates.
// Reset (rst_n, async low) clears control and config, but sets degree 3, range_max 1.0;
// points undefined until written. The receiver cannot stall: done is a one-cycle strobe.
module bspline_de_boor_evaluator #(
    parameter int MAX_POINTS = bsde_pkg::MAX_POINTS_DEF,
    parameter int MAX_DEGREE = bsde_pkg::MAX_DEGREE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command request
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic [bsde_pkg::PIW-1:0]       point_index,
    input  logic signed [bsde_pkg::QW-1:0] write_x,
    input  logic signed [bsde_pkg::QW-1:0] write_y,
    input  logic signed [bsde_pkg::QW-1:0] write_z,
    input  logic signed [bsde_pkg::QW-1:0] param_t,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bsde_pkg::CIW-1:0]       cfg_index,
    input  logic [bsde_pkg::QW-1:0]        cfg_data,
    // result
    output logic                           done,
    output logic signed [bsde_pkg::QW-1:0] out_x,
    output logic signed [bsde_pkg::QW-1:0] out_y,
    output logic signed [bsde_pkg::QW-1:0] out_z,
    output logic [1:0]                     curve_status
);

    import bsde_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int DGW = $clog2(MAX_DEGREE + 1);
    localparam int DCW = $clog2(DNW);
    localparam int PTW = $bits(point_t);

    // configuration registers
    logic [CW-1:0]        cv_count_reg;
    logic [1:0]           degree_reg;
    logic                 remap_reg;
    logic signed [QW-1:0] range_min_reg;
    logic signed [QW-1:0] range_max_reg;

    // control
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;         // return point of the knot lookup
    state_t div_ret_reg, div_ret_next; // return point of the divider
    logic   done_reg, done_next;

    // working registers
    logic [CW-1:0]        n_reg, n_next;
    logic [DGW-1:0]       deg_reg, deg_next;
    logic [CW-1:0]        spans_reg, spans_next;
    logic signed [QW-1:0] x_reg, x_next;
    logic                 at_end_reg, at_end_next;
    logic [CW-1:0]        span_reg, span_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [CW-1:0]        knot_k_reg, knot_k_next;
    logic signed [QW-1:0] knot_reg, knot_next;
    logic signed [QW-1:0] lo_reg, lo_next;
    logic [16:0]          a_reg, a_next;
    logic [DGW-1:0]       r_reg, r_next;
    logic [DGW-1:0]       j_reg, j_next;
    logic [1:0]           c_reg, c_next;
    point_t               p_reg, p_next;
    point_t               q_reg, q_next;
    logic signed [MW-1:0] acc_reg, acc_next;
    logic signed [MW-1:0] prod_reg, prod_next;
    point_t               d_reg [MAX_DEGREE+1];
    point_t               d_next [MAX_DEGREE+1];
    point_t               out_reg, out_next;
    logic [1:0]           status_reg, status_next;

    // divider
    logic [DNW-1:0] div_quo_reg, div_quo_next;
    logic [DDW-1:0] div_rem_reg, div_rem_next;
    logic [DDW-1:0] div_den_reg, div_den_next;
    logic           div_neg_reg, div_neg_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;

    // point store
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [PTW-1:0] ram_rdata_w;
    point_t        ram_rdata;
    point_t        wr_point;

    // sample entry
    logic [8:0]           n9;
    logic [CW-1:0]        n_w;
    logic [IXW-1:0]       dg8;
    logic [IXW-1:0]       n_m1;
    logic [DGW-1:0]       deg_w;
    logic [CW-1:0]        spans_w;
    logic signed [QW-1:0] end_w;
    logic signed [QW-1:0] start_w;
    logic signed [QW-1:0] x_w;
    logic                 at_end_w;

    // step indices and alpha
    logic [IXW-1:0]        left8, right8;
    logic signed [IXW-1:0] kl8, kr8;
    logic [CW-1:0]         kl, kr;
    logic signed [QW:0]    diff33;
    logic signed [QW:0]    den33;
    logic signed [QW:0]    xl33;
    logic signed [48:0]    num49;

    // shared arithmetic
    logic signed [QW:0]    mul_a;
    logic signed [AFW-1:0] mul_b;
    logic signed [QW-1:0]  pc, qc;
    logic signed [MW-1:0]  bl_sum;
    logic signed [QW-1:0]  bl_res;
    logic [DGW-1:0]        dsel;
    point_t                d_rd;
    logic [DNW-1:0]        ld_num, ld_mag;
    logic [DDW-1:0]        ld_den;
    logic [DDW+1:0]        trial;
    logic                  ge;
    logic signed [DNW:0]   q_ext, rnz_ext, divq;
    logic [CW-1:0]         load_addr;

    function automatic logic knot_inside(input logic signed [QW-1:0] kv,
                                         input logic signed [QW-1:0] xv,
                                         input logic                 at_end);
        return at_end ? (kv < xv) : (kv <= xv);
    endfunction

    function automatic logic [CW-1:0] clamp_k(input logic signed [IXW-1:0] v,
                                              input logic [CW-1:0]         hi);
        logic signed [IXW-1:0] hs;
        hs = $signed(IXW'(hi));
        if (v < 0)
            return '0;
        else if (v > hs)
            return hi;
        else
            return CW'(v);
    endfunction

    function automatic logic signed [QW-1:0] coord(input point_t p, input logic [1:0] c);
        case (c)
            2'd0:    return p.x;
            2'd1:    return p.y;
            default: return p.z;
        endcase
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign out_x     = out_reg.x;
    assign out_y     = out_reg.y;
    assign out_z     = out_reg.z;
    assign curve_status = status_reg;

    // ---------------- point store ----------------
    assign wr_point  = '{x: write_x, y: write_y, z: write_z};
    assign ram_we    = start && !busy && (cmd == CMD_WRITE)
                       && (9'(point_index) < 9'(MAX_POINTS));
    assign load_addr = span_reg - CW'(deg_reg) + CW'(j_reg);
    assign ram_raddr = (state_reg == S_LOAD) ? AW'(load_addr) : '0;
    assign ram_rdata = point_t'(ram_rdata_w);

    bsde_ram #(
        .WIDTH (PTW),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(point_index)),
        .wdata (wr_point),
        .raddr (ram_raddr),
        .rdata (ram_rdata_w)
    );

    // ---------------- sample setup: count, degree, domain clamp ----------------
    always_comb
    begin
        n9   = (9'(cv_count_reg) > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : 9'(cv_count_reg);
        n_w  = CW'(n9);
        n_m1 = IXW'(n_w) - IXW'(1);
        dg8  = IXW'(degree_reg);
        if (dg8 > n_m1)
            dg8 = n_m1;
        if (dg8 > IXW'(MAX_DEGREE))
            dg8 = IXW'(MAX_DEGREE);
        deg_w   = DGW'(dg8);
        spans_w = n_w - CW'(deg_w);
        // last knot is range_max exactly when remapped
        end_w   = remap_reg ? range_max_reg : QW'({spans_w, 16'h0000});
        start_w = remap_reg ? range_min_reg : '0;
        x_w     = (param_t > end_w) ? end_w : param_t;
        if (x_w < start_w)
            x_w = start_w;
        at_end_w = !(x_w < end_w);
    end

    // ---------------- step indices, alpha operands ----------------
    always_comb
    begin
        left8  = IXW'(j_reg) + IXW'(span_reg) - IXW'(deg_reg);
        right8 = IXW'(j_reg) + IXW'(1) + IXW'(span_reg) - IXW'(r_reg);
        kl8    = $signed(left8 - IXW'(deg_reg));
        kr8    = $signed(right8 - IXW'(deg_reg));
        kl     = clamp_k(kl8, spans_reg);
        kr     = clamp_k(kr8, spans_reg);
        diff33 = {range_max_reg[QW-1], range_max_reg} - {range_min_reg[QW-1], range_min_reg};
        den33  = {knot_reg[QW-1], knot_reg} - {lo_reg[QW-1], lo_reg};
        xl33   = {x_reg[QW-1], x_reg} - {lo_reg[QW-1], lo_reg};
        num49  = {xl33, 16'h0000};
    end

    // ---------------- shared multiplier and blend ----------------
    always_comb
    begin
        pc    = coord(p_reg, c_reg);
        qc    = coord(q_reg, c_reg);
        mul_a = diff33;
        mul_b = AFW'(knot_k_reg);
        case (state_reg)
            S_BL_M1:
            begin
                mul_a = {pc[QW-1], pc};
                mul_b = {1'b0, ONE_Q - a_reg};
            end
            S_BL_M2:
            begin
                mul_a = {qc[QW-1], qc};
                mul_b = {1'b0, a_reg};
            end
            default:
            begin
                mul_a = diff33;
                mul_b = AFW'(knot_k_reg);
            end
        endcase
        bl_sum = acc_reg + prod_reg + MW'(32768);
        bl_res = bl_sum[47:16];
        dsel   = (state_reg == S_RDP) ? (j_reg - DGW'(1)) : j_reg;
        d_rd   = d_reg[dsel];
    end

    // ---------------- divider datapath ----------------
    always_comb
    begin
        ld_num  = (state_reg == S_KNOT_MUL) ? prod_reg[DNW-1:0] : {num49[48], num49};
        ld_den  = (state_reg == S_KNOT_MUL) ? DDW'(spans_reg) : DDW'(den33);
        ld_mag  = ld_num[DNW-1] ? (~ld_num + DNW'(1)) : ld_num;
        trial   = {1'b0, div_rem_reg, div_quo_reg[DNW-1]} - {2'b00, div_den_reg};
        ge      = !trial[DDW+1];
        q_ext   = {1'b0, div_quo_reg};
        rnz_ext = (DNW+1)'(|div_rem_reg);
        // floor for negative dividends
        divq    = div_neg_reg ? (-q_ext - rnz_ext) : q_ext;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        div_ret_next = div_ret_reg;
        done_next    = 1'b0;
        n_next       = n_reg;
        deg_next     = deg_reg;
        spans_next   = spans_reg;
        x_next       = x_reg;
        at_end_next  = at_end_reg;
        span_next    = span_reg;
        k_next       = k_reg;
        knot_k_next  = knot_k_reg;
        knot_next    = knot_reg;
        lo_next      = lo_reg;
        a_next       = a_reg;
        r_next       = r_reg;
        j_next       = j_reg;
        c_next       = c_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        acc_next     = acc_reg;
        prod_next    = mul_a * mul_b;
        d_next       = d_reg;
        out_next     = out_reg;
        status_next  = status_reg;
        div_quo_next = div_quo_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        div_neg_next = div_neg_reg;
        div_cnt_next = div_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start && (cmd == CMD_SAMPLE))
                begin
                    n_next      = n_w;
                    deg_next    = deg_w;
                    spans_next  = spans_w;
                    x_next      = x_w;
                    at_end_next = at_end_w;
                    k_next      = CW'(1);
                    j_next      = '0;
                    if (n_w == '0)
                    begin
                        out_next    = '0;
                        status_next = ST_EMPTY;
                        done_next   = 1'b1;
                    end
                    else if (n_w == CW'(1))
                    begin
                        state_next = S_SINGLE;
                    end
                    else if (knot_inside(end_w, x_w, at_end_w))
                    begin
                        span_next  = n_w - CW'(1);
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        span_next  = CW'(deg_w);
                        state_next = S_SRCH;
                    end
                end
            end
            S_SINGLE:
            begin
                out_next    = ram_rdata;
                status_next = ST_SINGLE;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_SRCH:
            begin
                if (k_reg >= spans_reg)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    knot_k_next = k_reg;
                    ret_next    = S_SRCH_CHK;
                    state_next  = S_KNOT;
                end
            end
            S_SRCH_CHK:
            begin
                // knots are monotone: stop at the first one past x
                if (knot_inside(knot_reg, x_reg, at_end_reg))
                begin
                    span_next  = span_reg + CW'(1);
                    k_next     = k_reg + CW'(1);
                    state_next = S_SRCH;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_KNOT:
            begin
                if (remap_reg)
                begin
                    state_next = S_KNOT_MUL;
                end
                else
                begin
                    knot_next  = QW'({knot_k_reg, 16'h0000});
                    state_next = ret_reg;
                end
            end
            S_KNOT_MUL:
            begin
                div_quo_next = ld_mag;
                div_rem_next = '0;
                div_den_next = ld_den;
                div_neg_next = ld_num[DNW-1];
                div_cnt_next = '0;
                div_ret_next = S_KNOT_FIN;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                div_rem_next = ge ? trial[DDW-1:0] : {div_rem_reg[DDW-2:0], div_quo_reg[DNW-1]};
                div_quo_next = {div_quo_reg[DNW-2:0], ge};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(DNW - 1))
                    state_next = div_ret_reg;
            end
            S_KNOT_FIN:
            begin
                knot_next  = range_min_reg + divq[QW-1:0];
                state_next = ret_reg;
            end
            S_LOAD:
            begin
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR:
            begin
                d_next[j_reg] = ram_rdata;
                if (j_reg == deg_reg)
                begin
                    if (deg_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        r_next     = DGW'(1);
                        state_next = S_STEP;
                    end
                end
                else
                begin
                    j_next     = j_reg + DGW'(1);
                    state_next = S_LOAD;
                end
            end
            S_STEP:
            begin
                knot_k_next = kl;
                ret_next    = S_STEP_LO;
                state_next  = S_KNOT;
            end
            S_STEP_LO:
            begin
                lo_next     = knot_reg;
                knot_k_next = kr;
                ret_next    = S_STEP_HI;
                state_next  = S_KNOT;
            end
            S_STEP_HI:
            begin
                // knot_reg holds the right knot here
                if ((den33 <= 0) || (num49 <= 0))
                begin
                    a_next     = '0;
                    state_next = S_RDP;
                end
                else
                begin
                    div_quo_next = ld_mag;
                    div_rem_next = '0;
                    div_den_next = ld_den;
                    div_neg_next = 1'b0;
                    div_cnt_next = '0;
                    div_ret_next = S_ALPHA_FIN;
                    state_next   = S_DIV;
                end
            end
            S_ALPHA_FIN:
            begin
                a_next     = (div_quo_reg > DNW'(ONE_Q)) ? ONE_Q : div_quo_reg[16:0];
                state_next = S_RDP;
            end
            S_RDP:
            begin
                p_next     = d_rd;
                state_next = S_RDQ;
            end
            S_RDQ:
            begin
                q_next     = d_rd;
                c_next     = '0;
                state_next = S_BL_M1;
            end
            S_BL_M1:
            begin
                state_next = S_BL_M2;
            end
            S_BL_M2:
            begin
                acc_next   = prod_reg;
                state_next = S_BL_ACC;
            end
            S_BL_ACC:
            begin
                case (c_reg)
                    2'd0:    d_next[j_reg].x = bl_res;
                    2'd1:    d_next[j_reg].y = bl_res;
                    default: d_next[j_reg].z = bl_res;
                endcase
                if (c_reg == 2'd2)
                begin
                    if (j_reg == r_reg)
                    begin
                        if (r_reg == deg_reg)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            r_next     = r_reg + DGW'(1);
                            j_next     = deg_reg;
                            state_next = S_STEP;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg - DGW'(1);
                        state_next = S_STEP;
                    end
                end
                else
                begin
                    c_next     = c_reg + 2'd1;
                    state_next = S_BL_M1;
                end
            end
            S_FINISH:
            begin
                // j equals deg here
                out_next    = d_rd;
                status_next = ST_EVAL;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            div_ret_reg <= S_IDLE;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            div_ret_reg <= div_ret_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_count_reg  <= '0;
            degree_reg    <= 2'd3;
            remap_reg     <= 1'b0;
            range_min_reg <= '0;
            range_max_reg <= 32'sd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CV_COUNT:  cv_count_reg  <= cfg_data[CW-1:0];
                CFG_DEGREE:    degree_reg    <= cfg_data[1:0];
                CFG_REMAP:     remap_reg     <= cfg_data[0];
                CFG_RANGE_MIN: range_min_reg <= cfg_data;
                CFG_RANGE_MAX: range_max_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        deg_reg     <= deg_next;
        spans_reg   <= spans_next;
        x_reg       <= x_next;
        at_end_reg  <= at_end_next;
        span_reg    <= span_next;
        k_reg       <= k_next;
        knot_k_reg  <= knot_k_next;
        knot_reg    <= knot_next;
        lo_reg      <= lo_next;
        a_reg       <= a_next;
        r_reg       <= r_next;
        j_reg       <= j_next;
        c_reg       <= c_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        d_reg       <= d_next;
        out_reg     <= out_next;
        status_reg  <= status_next;
        div_quo_reg <= div_quo_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_neg_reg <= div_neg_next;
        div_cnt_reg <= div_cnt_next;
    end

`ifndef SYNTHESIS
    a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> ((span_reg >= CW'(deg_reg)) && (span_reg < n_reg)))
        else $error("span outside [deg, n-1]");

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDP) |-> (a_reg <= ONE_Q))
        else $error("alpha above one");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_den_reg != '0))
        else $error("divide by zero");

    a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDP) |-> ((j_reg >= r_reg) && (r_reg != '0)))
        else $error("de Boor indices out of order");

    a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> (done && (state_reg == S_IDLE)))
        else $error("result not strobed after finish");
`endif

endmodule
